[hw/rtl/tcw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Field widths, mode codes, character codes and the control/status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // input transfer this cycle
      logic sweep;       // schedule one store write at the sweep pointer
      logic move;        // sweep copies the cell one row below
      logic reset_attr;  // blank cells take the reset attribute
      logic emit;        // load the result register
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic item_clear;     // offered item is a clear
      logic item_scroll;    // offered item overflows the last row
      logic ptr_last;       // sweep pointer on the last cell
      logic ptr_last_move;  // sweep pointer on the last cell that is copied
      logic wr_busy;        // store write still pending
   } dp_sts_type;

endpackage
`default_nettype wire

[hw/rtl/tcw_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_req_if: request channel of the text console writer
// Valid/ready channel carrying one console command.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   import tcw_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [CHAR_W-1:0]   char_code;
   logic [ATTR_W-1:0]   color;
   logic [INDEX_W-1:0]  cell_index;

   modport source (output valid, mode, char_code, color, cell_index, input ready);
   modport sink   (input valid, mode, char_code, color, cell_index, output ready);
endinterface
`default_nettype wire

[hw/rtl/tcw_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_rsp_if: response channel of the text console writer
// Valid/ready channel carrying the read cell and the cursor position.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_W-1:0]    cell_char;
   logic [ATTR_W-1:0]    cell_color;
   logic [ROW_OUT_W-1:0] row_now;
   logic [COL_OUT_W-1:0] col_now;

   modport source (output valid, cell_char, cell_color, row_now, col_now, input ready);
   modport sink   (input valid, cell_char, cell_color, row_now, col_now, output ready);
endinterface
`default_nettype wire

[hw/rtl/tcw_csr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_csr_if: configuration write channel of the text console writer
// Valid/ready channel carrying the blank attribute.
// ----------------------------------------------------------------------------
interface tcw_csr_if;
   import tcw_pkg::*;

   logic               valid;
   logic               ready;
   logic [ATTR_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/tcw_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: screen store, cursor and result register
// One write port and one registered read port on the screen store; all
// store writes go through a one-entry pending write register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tcw_pkg::ctl_cmd_type          cmd,
   output tcw_pkg::dp_sts_type                sts,
   input  wire logic [tcw_pkg::MODE_W-1:0]    mode,
   input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
   input  wire logic [tcw_pkg::ATTR_W-1:0]    color,
   input  wire logic [tcw_pkg::INDEX_W-1:0]   cell_index,
   input  wire logic                          csr_we,
   input  wire logic [tcw_pkg::ATTR_W-1:0]    csr_data,
   output logic [tcw_pkg::CHAR_W-1:0]         cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]         cell_color,
   output logic [tcw_pkg::ROW_OUT_W-1:0]      row_now,
   output logic [tcw_pkg::COL_OUT_W-1:0]      col_now
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int MOVED = (ROWS - 1) * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int IW    = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;
   localparam int DW    = CHAR_W + ATTR_W;

   logic [DW-1:0]     mem [CELLS];

   logic [ATTR_W-1:0] blank_attr_ff;
   logic [RW-1:0]     row_ff;
   logic [CW-1:0]     col_ff;
   logic [AW-1:0]     row_base_ff;
   logic [AW-1:0]     ptr_ff;
   logic              wr_vld_ff;
   logic              wr_move_ff;
   logic [AW-1:0]     wr_addr_ff;
   logic [DW-1:0]     wr_data_ff;
   logic [DW-1:0]     rd_data_ff;
   logic [MODE_W-1:0] mode_ff;
   logic              in_range_ff;

   logic              is_put;
   logic              is_nl;
   logic              col_last;
   logic              row_last;
   logic              line_end;
   logic              in_range;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [ATTR_W-1:0] sweep_attr;

   logic [RW+ROW_OUT_W-1:0] row_wide;
   logic [CW+COL_OUT_W-1:0] col_wide;

   assign is_put   = (mode == MODE_PUT);
   assign is_nl    = (char_code == CHAR_NEWLINE);
   assign col_last = (col_ff == CW'(COLUMNS - 1));
   assign row_last = (row_ff == RW'(ROWS - 1));
   assign line_end = is_nl || col_last;
   assign in_range = (IW'(cell_index) < IW'(CELLS));

   assign sts.item_clear    = (mode == MODE_CLEAR);
   assign sts.item_scroll   = is_put && line_end && row_last;
   assign sts.ptr_last      = (ptr_ff == AW'(CELLS - 1));
   assign sts.ptr_last_move = (ptr_ff == AW'(MOVED - 1));
   assign sts.wr_busy       = wr_vld_ff;

   assign sweep_attr = cmd.reset_attr ? RESET_ATTR : blank_attr_ff;

   // read port: requested cell on a read transfer, next row's cell while scrolling
   assign rd_en   = (cmd.accept && (mode == MODE_READ) && in_range) ||
                    (cmd.sweep && cmd.move);
   assign rd_addr = cmd.sweep ? ptr_ff + AW'(COLUMNS) : AW'(cell_index);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_vld_ff) begin
         mem[wr_addr_ff] <= wr_move_ff ? rd_data_ff : wr_data_ff;
      end
   end

   // control state: attribute, cursor, sweep pointer, pending write
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_attr_ff <= RESET_ATTR;
         row_ff        <= '0;
         col_ff        <= '0;
         row_base_ff   <= '0;
         ptr_ff        <= '0;
         wr_vld_ff     <= 1'b0;
         wr_move_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            blank_attr_ff <= csr_data;
         end

         if (cmd.sweep) begin
            ptr_ff <= sts.ptr_last ? '0 : ptr_ff + 1'b1;
         end

         if (cmd.accept && is_put && !is_nl) begin
            wr_vld_ff  <= 1'b1;
            wr_move_ff <= 1'b0;
         end else if (cmd.sweep) begin
            wr_vld_ff  <= 1'b1;
            wr_move_ff <= cmd.move;
         end else begin
            wr_vld_ff  <= 1'b0;
            wr_move_ff <= 1'b0;
         end

         if (cmd.accept) begin
            case (mode)
               MODE_PUT: begin
                  if (sts.item_scroll) begin
                     row_ff      <= RW'(ROWS - 1);
                     col_ff      <= '0;
                     row_base_ff <= AW'(MOVED);
                  end else if (line_end) begin
                     row_ff      <= row_ff + 1'b1;
                     col_ff      <= '0;
                     row_base_ff <= row_base_ff + AW'(COLUMNS);
                  end else begin
                     col_ff      <= col_ff + 1'b1;
                  end
               end
               MODE_CLEAR: begin
                  row_ff      <= '0;
                  col_ff      <= '0;
                  row_base_ff <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers: pending write data, latched item, result
   always_ff @(posedge clock) begin
      if (cmd.accept && is_put && !is_nl) begin
         wr_addr_ff <= row_base_ff + AW'(col_ff);
         wr_data_ff <= {char_code, color};
      end else if (cmd.sweep) begin
         wr_addr_ff <= ptr_ff;
         wr_data_ff <= {CHAR_SPACE, sweep_attr};
      end
      if (cmd.accept) begin
         mode_ff     <= mode;
         in_range_ff <= in_range;
      end
      if (cmd.emit) begin
         if (mode_ff == MODE_READ) begin
            if (in_range_ff) begin
               cell_char  <= rd_data_ff[DW-1:ATTR_W];
               cell_color <= rd_data_ff[ATTR_W-1:0];
            end else begin
               cell_char  <= CHAR_SPACE;
               cell_color <= blank_attr_ff;
            end
         end else begin
            cell_char  <= '0;
            cell_color <= '0;
         end
         row_now <= row_wide[ROW_OUT_W-1:0];
         col_now <= col_wide[COL_OUT_W-1:0];
      end
   end

   assign row_wide = (RW + ROW_OUT_W)'(row_ff);
   assign col_wide = (CW + COL_OUT_W)'(col_ff);

   a_move_below_last_row: assert property (@(posedge clock) disable iff (reset)
      (wr_vld_ff && wr_move_ff) |-> (wr_addr_ff < AW'(MOVED)))
      else $error("row copy targets the bottom row");

   // compare one bit wider so a power-of-two screen size does not wrap to zero
   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (({1'b0, row_ff} < (RW + 1)'(ROWS)) &&
                      ({1'b0, col_ff} < (CW + 1)'(COLUMNS))))
      else $error("cursor left the screen");

   a_put_write_follows: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && is_put && !is_nl) |=> (wr_vld_ff && !wr_move_ff))
      else $error("character write not scheduled");

endmodule
`default_nettype wire

[hw/rtl/tcw_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing state machine of the text console writer
// Runs the power-up blank sweep, takes one item at a time, walks the store
// for clear and scroll, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire tcw_pkg::dp_sts_type  sts,
   output tcw_pkg::ctl_cmd_type      cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_MOVE,
      ST_BLANK,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE) && !sts.wr_busy;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep      = 1'b1;
            cmd.reset_attr = 1'b1;
         end
         ST_IDLE: begin
            cmd.accept = req_valid && req_ready;
         end
         ST_CLEAR, ST_BLANK: begin
            cmd.sweep = 1'b1;
         end
         ST_MOVE: begin
            cmd.sweep = 1'b1;
            cmd.move  = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               if (sts.ptr_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (cmd.accept) begin
                  if (sts.item_clear) begin
                     state_ff <= ST_CLEAR;
                  end else if (sts.item_scroll) begin
                     state_ff <= ST_MOVE;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_CLEAR, ST_BLANK: begin
               if (sts.ptr_last) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_MOVE: begin
               if (sts.ptr_last_move) begin
                  state_ff <= ST_BLANK;
               end
            end
            ST_EMIT: begin
               if (cmd.emit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_INIT;
            end
         endcase
      end
   end

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result loaded without valid");

   a_move_then_blank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && sts.ptr_last_move) |=> (state_ff == ST_BLANK))
      else $error("row copy did not hand over to bottom row blanking");

endmodule
`default_nettype wire

[hw/rtl/text_console_writer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Screen store of ROWS x COLUMNS character/attribute cells with a cursor;
// puts characters, handles newline, wrap and scroll, clears and reads cells.
// ----------------------------------------------------------------------------
//
//   channel  dir  fields                                   transfer
//   req      in   mode, char_code, color, cell_index       valid & ready
//   rsp      out  cell_char, cell_color, row_now, col_now  valid & ready
//   csr      in   data (blank attribute)                   valid & ready
//
// Put, newline and read go from the transfer to ST_EMIT, which loads the result.
// Clear and scroll sweep the whole screen store: it has one write port, so
// every cell is swept once, one per cycle.
// After reset a blank sweep of every cell, then a drain of the pending write,
// runs before the first request transfer; csr writes are taken throughout.
// A stalled rsp holds the result register; the next item may be taken while
// it waits, and its own result waits until the register frees up.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tcw_req_if.sink    req,
   tcw_rsp_if.source  rsp,
   tcw_csr_if.sink    csr
);
   import tcw_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // The attribute register takes every write at once: never stall csr.
   assign csr.ready = 1'b1;

   // Sequencer: owns request ready, result valid and the store sweeps.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: screen store, cursor and result payload.
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .mode       (req.mode),
      .char_code  (req.char_code),
      .color      (req.color),
      .cell_index (req.cell_index),
      .csr_we     (csr.valid),
      .csr_data   (csr.data),
      .cell_char  (rsp.cell_char),
      .cell_color (rsp.cell_color),
      .row_now    (rsp.row_now),
      .col_now    (rsp.col_now)
   );

endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_writer
// Drives console commands (put, newline, clear, read, spare mode) over the
// request channel, mirrors the screen store and cursor in a local model and
// compares every response field against it or a typed expectation. A short
// table of directed commands comes first, then random text with reads, under
// several blank attributes and with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   // Mode code that the block must ignore
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   // Blank attribute written right after reset; the directed table relies on it
   localparam logic [ATTR_W-1:0] BOOT_ATTR = 8'h00;

   localparam int DIRECTED_ROWS   = 25;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int HOLD_AT         = 400;    // request transfers before the long stall
   localparam int HOLD_CYCLES     = 300;
   localparam int SWEEP_PAUSE     = CELLS + 16;

   // Worst case is far below this: even if every command were a full-screen
   // sweep the run would take about 4.4 ms.
   localparam int LIMIT_NS = 20_000_000;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CHAR_W-1:0]  char_code;
      logic [ATTR_W-1:0]  color;
      logic [INDEX_W-1:0] cell_index;
   } console_cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0]    cell_char;
      logic [ATTR_W-1:0]    cell_color;
      logic [ROW_OUT_W-1:0] row_now;
      logic [COL_OUT_W-1:0] col_now;
   } cell_report_type;

   typedef struct packed {
      console_cmd_type cmd;
      logic [7:0]      reps;
      logic            typed_valid;
      cell_report_type typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic hold_rsp;

   tcw_req_if req_ch ();
   tcw_rsp_if rsp_ch ();
   tcw_csr_if csr_ch ();

   text_console_writer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Screen mirror: character and attribute per cell, cursor, blank attribute
   // ------------------------------------------------------------------------
   logic [CHAR_W-1:0] mirror_char [CELLS];
   logic [ATTR_W-1:0] mirror_attr [CELLS];
   int unsigned       cur_row;
   int unsigned       cur_col;
   logic [ATTR_W-1:0] blank_attr;

   cell_report_type pending_results [$];
   int unsigned     error_count;
   int unsigned     results_seen;
   int unsigned     accepted_count;

   // Request pacing: bursts of transfers separated by idle gaps
   int unsigned burst_left;
   bit          gaps_on;
   bit          req_live;

   // Apply one command to the mirror and return the response it must produce.
   function automatic cell_report_type console_apply(input console_cmd_type cmd);
      cell_report_type res;
      int unsigned     at;
      res = '0;
      case (cmd.mode)
         MODE_PUT: begin
            if (cmd.char_code == CHAR_NEWLINE) begin
               cur_row++;
               cur_col = 0;
            end else begin
               at = cur_row * COLUMNS + cur_col;
               if (at < CELLS) begin
                  mirror_char[at] = cmd.char_code;
                  mirror_attr[at] = cmd.color;
               end
               cur_col++;
               if (cur_col >= COLUMNS) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            // Row overflow: move every row up one and blank the bottom row
            if (cur_row >= ROWS) begin
               for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                  mirror_char[i] = mirror_char[i + COLUMNS];
                  mirror_attr[i] = mirror_attr[i + COLUMNS];
               end
               for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
                  mirror_char[i] = CHAR_SPACE;
                  mirror_attr[i] = blank_attr;
               end
               cur_row = ROWS - 1;
               cur_col = 0;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               mirror_char[i] = CHAR_SPACE;
               mirror_attr[i] = blank_attr;
            end
            cur_row = 0;
            cur_col = 0;
         end
         MODE_READ: begin
            if (cmd.cell_index < CELLS) begin
               res.cell_char  = mirror_char[cmd.cell_index];
               res.cell_color = mirror_attr[cmd.cell_index];
            end else begin
               res.cell_char  = CHAR_SPACE;
               res.cell_color = blank_attr;
            end
         end
         default: ;
      endcase
      res.row_now = ROW_OUT_W'(cur_row);
      res.col_now = COL_OUT_W'(cur_col);
      return res;
   endfunction

   // Random command: mostly text lines, reads near the cursor, some noise.
   // Long-line phases drop most newlines so that rows wrap.
   function automatic console_cmd_type pick_command(input bit long_lines);
      console_cmd_type cmd;
      int unsigned     roll;
      int unsigned     here;
      int unsigned     back;
      cmd.mode       = MODE_PUT;
      cmd.char_code  = CHAR_W'($urandom);
      cmd.color      = ATTR_W'($urandom);
      cmd.cell_index = INDEX_W'($urandom);
      roll = $urandom_range(0, 999);
      here = cur_row * COLUMNS + cur_col;
      if (roll < (long_lines ? 680 : 520)) begin
         // plain character, random byte and color
      end else if (roll < 690) begin
         cmd.char_code = CHAR_NEWLINE;
      end else if (roll < 860) begin
         back = $urandom_range(1, 160);
         cmd.mode = MODE_READ;
         cmd.cell_index = (here >= back) ? INDEX_W'(here - back)
                                         : INDEX_W'($urandom_range(0, CELLS - 1));
      end else if (roll < 930) begin
         cmd.mode = MODE_READ;
      end else if (roll < 965) begin
         cmd.mode = MODE_READ;
         cmd.cell_index = INDEX_W'($urandom_range(CELLS, 2047));
      end else if (roll < 994) begin
         cmd.mode = MODE_SPARE;
      end else begin
         cmd.mode = MODE_CLEAR;
      end
      return cmd;
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10)
         $display("ERROR: %s", what);
   endtask

   // Offer one command, wait for its transfer, record the expected response.
   // A typed expectation, where given, replaces the mirror's answer.
   task automatic offer_command(input console_cmd_type cmd, input bit typed_valid,
                                input cell_report_type typed);
      cell_report_type predicted;
      req_ch.valid      <= 1'b1;
      req_ch.mode       <= cmd.mode;
      req_ch.char_code  <= cmd.char_code;
      req_ch.color      <= cmd.color;
      req_ch.cell_index <= cmd.cell_index;
      req_live = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      // Record before any gap so the response can never outrun its expectation
      predicted = console_apply(cmd);
      pending_results.push_back(typed_valid ? typed : predicted);
      accepted_count++;
      if (gaps_on) begin
         if (burst_left != 0)
            burst_left--;
         if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            req_live = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic write_blank_attr(input logic [ATTR_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      blank_attr = value;
      csr_ch.valid <= 1'b0;
   endtask

   // Drop the request, drain all responses, then let any trailing sweep finish.
   task automatic settle_block();
      if (req_live) begin
         req_ch.valid <= 1'b0;
         req_live = 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SWEEP_PAUSE) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Directed commands. Rows with typed_valid set carry the response as read
   // off the spec; the rest are checked against the mirror.
   // ------------------------------------------------------------------------
   stim_row_type directed_table [DIRECTED_ROWS] = '{
      // reset contents: spaces in the reset attribute, whatever was written since
      '{'{MODE_READ,  8'h00, 8'h00, 11'd0},    8'd1,  1'b1, '{CHAR_SPACE, RESET_ATTR, 5'd0, 7'd0}},
      '{'{MODE_READ,  8'hFF, 8'hFF, 11'd1999}, 8'd1,  1'b1, '{CHAR_SPACE, RESET_ATTR, 5'd0, 7'd0}},
      // reads past the screen give a space in the current blank attribute
      '{'{MODE_READ,  8'h00, 8'h00, 11'd2000}, 8'd1,  1'b1, '{CHAR_SPACE, BOOT_ATTR, 5'd0, 7'd0}},
      '{'{MODE_READ,  8'hFF, 8'hFF, 11'h7FF},  8'd1,  1'b1, '{CHAR_SPACE, BOOT_ATTR, 5'd0, 7'd0}},
      // spare mode changes nothing
      '{'{MODE_SPARE, 8'hFF, 8'hFF, 11'h7FF},  8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{'{MODE_PUT,   8'h41, 8'h1E, 11'd0},    8'd1,  1'b0, '0},
      // character zero is stored like any other
      '{'{MODE_PUT,   8'h00, 8'h00, 11'd0},    8'd1,  1'b0, '0},
      '{'{MODE_PUT,   8'hFF, 8'hFF, 11'h7FF},  8'd1,  1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd0},    8'd1,  1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd1},    8'd1,  1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd2},    8'd1,  1'b0, '0},
      '{'{MODE_PUT,   CHAR_NEWLINE, 8'h55, 11'd0}, 8'd1, 1'b0, '0},
      // one full row: wrap at the row end
      '{'{MODE_PUT,   8'h7E, 8'h5A, 11'd0},    8'd80, 1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd159},  8'd1,  1'b0, '0},
      '{'{MODE_PUT,   CHAR_NEWLINE, 8'hAA, 11'h7FF}, 8'd22, 1'b0, '0},
      // newline on the last row scrolls
      '{'{MODE_PUT,   CHAR_NEWLINE, 8'h00, 11'd0}, 8'd1, 1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd0},    8'd1,  1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd1920}, 8'd1,  1'b0, '0},
      // fill the last row: the wrap scrolls
      '{'{MODE_PUT,   8'h23, 8'hC3, 11'd0},    8'd80, 1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd1840}, 8'd1,  1'b0, '0},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd1920}, 8'd1,  1'b0, '0},
      '{'{MODE_CLEAR, 8'hFF, 8'hFF, 11'h7FF},  8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{'{MODE_READ,  8'h00, 8'h00, 11'd0},    8'd1,  1'b1, '{CHAR_SPACE, BOOT_ATTR, 5'd0, 7'd0}},
      '{'{MODE_READ,  8'hFF, 8'hFF, 11'd1999}, 8'd1,  1'b1, '{CHAR_SPACE, BOOT_ATTR, 5'd0, 7'd0}},
      '{'{MODE_SPARE, 8'h00, 8'h00, 11'd0},    8'd1,  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}}
   };

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [ATTR_W-1:0] phase_attr;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.mode       <= MODE_PUT;
      req_ch.char_code  <= '0;
      req_ch.color      <= '0;
      req_ch.cell_index <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.data       <= '0;
      error_count    = 0;
      accepted_count = 0;
      req_live       = 1'b0;
      gaps_on        = 1'b1;
      burst_left     = $urandom_range(1, 24);
      // Mirror starts from the reset state of the block
      for (int i = 0; i < CELLS; i++) begin
         mirror_char[i] = CHAR_SPACE;
         mirror_attr[i] = RESET_ATTR;
      end
      cur_row    = 0;
      cur_col    = 0;
      blank_attr = RESET_ATTR;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The block takes this during its power-up clear; cells keep the reset attribute
      write_blank_attr(BOOT_ATTR);

      foreach (directed_table[r]) begin
         for (int k = 0; k < directed_table[r].reps; k++)
            offer_command(directed_table[r].cmd, directed_table[r].typed_valid,
                          directed_table[r].typed);
      end

      // Random phases, each under its own blank attribute; phase 3 runs without gaps
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       phase_attr = 8'hFF;
            2:       phase_attr = RESET_ATTR;
            4:       phase_attr = 8'h00;
            default: phase_attr = ATTR_W'($urandom);
         endcase
         settle_block();
         write_blank_attr(phase_attr);
         gaps_on = (p != 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            offer_command(pick_command(p[0]), 1'b0, '0);
      end

      settle_block();
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d responses never arrived", pending_results.size()));
      if (error_count == 0)
         $display("text_console_writer verification clean");
      else
         $display("text_console_writer verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: stall on a random mask that the tick counter walks and re-picks.
   // Some masks are all ones, so long stretches run without stalls.
   // ------------------------------------------------------------------------
   initial begin : rsp_pacer
      logic [15:0] stall_mask;
      int unsigned tick;
      rsp_ch.ready <= 1'b0;
      stall_mask = '1;
      tick = 0;
      forever begin
         @(posedge clock);
         if (tick % 64 == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_mask = '1;
               1:       stall_mask = 16'($urandom);
               2:       stall_mask = 16'($urandom) | 16'($urandom);
               default: stall_mask = 16'hFF00 >> $urandom_range(0, 8);
            endcase
         end
         rsp_ch.ready <= stall_mask[tick % 16] & ~hold_rsp;
         tick++;
      end
   end

   // Hold off the response channel once for a long stretch while requests
   // keep coming, so the block backs up and drops its request ready.
   initial begin : rsp_holdoff
      hold_rsp <= 1'b0;
      wait (accepted_count >= HOLD_AT);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Response check: every transfer against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      cell_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            flag_error($sformatf("response %0d with nothing expected", results_seen));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.cell_char !== want.cell_char || rsp_ch.cell_color !== want.cell_color
                || rsp_ch.row_now !== want.row_now || rsp_ch.col_now !== want.col_now)
               flag_error($sformatf({"response %0d: expected char %02h color %02h ",
                                     "row %0d col %0d, got char %02h color %02h ",
                                     "row %0d col %0d"},
                                    results_seen, want.cell_char, want.cell_color,
                                    want.row_now, want.col_now, rsp_ch.cell_char,
                                    rsp_ch.cell_color, rsp_ch.row_now, rsp_ch.col_now));
         end
      end
   end

   initial results_seen = 0;

   // Hard stop if the run hangs
   initial begin : watchdog
      #LIMIT_NS;
      $display("text_console_writer verification failed");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_req_if.sv
hw/rtl/tcw_rsp_if.sv
hw/rtl/tcw_csr_if.sv
hw/rtl/tcw_datapath.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
verif/testbench.sv
